// ===== rtl/rpn_stack_evaluator_defines.svh =====
// Assertion macros shared by the RPN stack evaluator RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, p) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (p)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, p)
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/rse_pkg.sv =====
// Package for the RPN stack evaluator: widths, token and status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package rse_pkg;

    localparam int STACK_DEPTH_DEF = 4;
    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int STAT_W          = 3;
    localparam int DIV_STEPS       = 48;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_END  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FEW    = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIV0   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADOP  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADEND = 3'd5;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        RS_ZERO,
        RS_OPERAND,
        RS_TOP,
        RS_ADD,
        RS_SUB,
        RS_MUL,
        RS_DIV
    } res_sel_t;

    typedef enum logic [1:0] {
        SK_NONE,
        SK_PUSH,
        SK_POP,
        SK_CLEAR
    } stk_op_t;

    typedef struct packed {
        logic              accept;
        logic              res_load;
        res_sel_t          res_sel;
        logic              div_start;
        logic              commit;
        stk_op_t           stk_op;
        logic [STAT_W-1:0] status;
        logic              finished;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic lt2;
        logic eq1;
        logic y_zero;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rse_divider.sv =====
// Bit-serial restoring divider for Q16.16: (x * 2^16) / y, truncated toward
// zero and saturated. One quotient bit per cycle. Uses rse_pkg.
`default_nettype none

module rse_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [rse_pkg::DATA_W-1:0] dividend,
    input  wire logic signed [rse_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic signed [rse_pkg::DATA_W-1:0] quotient
);
    import rse_pkg::*;

    localparam int QW = DATA_W + 16;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;

    logic [DATA_W-1:0]    mag_x;
    logic [DATA_W-1:0]    mag_y;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W+1:0]    diff;
    logic                 ge;
    logic [DATA_W-1:0]    neg_q;

    assign mag_x  = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
    assign mag_y  = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
    assign rem_sh = {rem_reg, quo_reg[QW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~diff[DATA_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            quo_next  = {mag_x, 16'h0000};
            rem_next  = '0;
            dvs_next  = mag_y;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[QW-2:0], ge};
            rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign neg_q = DATA_W'(-quo_reg[DATA_W-1:0]);

    always_comb
    begin
        if (!neg_reg)
        begin
            if (|quo_reg[QW-1:DATA_W-1])
                quotient = Q_MAX;
            else
                quotient = quo_reg[DATA_W-1:0];
        end
        else
        begin
            if ((|quo_reg[QW-1:DATA_W]) || (quo_reg[DATA_W-1] && (|quo_reg[DATA_W-2:0])))
                quotient = Q_MIN;
            else
                quotient = neg_q;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/rse_datapath.sv =====
// Datapath of the RPN stack evaluator: operand stack memory, add/sub/mul
// units, the divider and the result registers. Uses rse_pkg, rse_divider.
`default_nettype none

`include "rpn_stack_evaluator_defines.svh"

module rse_datapath #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rse_pkg::dp_cmd_t                  cmd,
    output rse_pkg::dp_stat_t                      stat,
    input  wire logic signed [rse_pkg::DATA_W-1:0] operand_value,
    output logic [rse_pkg::STAT_W-1:0]             status,
    output logic signed [rse_pkg::DATA_W-1:0]      result_value,
    output logic [CNT_W-1:0]                       stack_depth,
    output logic                                   finished
);
    import rse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic signed [DATA_W-1:0] stk_mem [STACK_DEPTH];

    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [DATA_W-1:0]  opnd_reg;
    logic signed [DATA_W-1:0]  rd_x_reg;
    logic signed [DATA_W-1:0]  rd_y_reg;
    logic signed [63:0]        prod_reg;
    logic signed [DATA_W-1:0]  res_reg, res_next;
    logic [STAT_W-1:0]         status_reg;
    logic signed [DATA_W-1:0]  value_reg;
    logic [CNT_W-1:0]          depth_reg;
    logic                      fin_reg;

    logic [CNT_W-1:0]          count_m1;
    logic [CNT_W-1:0]          count_m2;
    logic [AW-1:0]             ra_x;
    logic [AW-1:0]             ra_y;
    logic                      we;
    logic [AW-1:0]             wa;
    logic signed [DATA_W-1:0]  wd;

    logic [DATA_W:0]           sum;
    logic [DATA_W:0]           dif;
    logic signed [DATA_W-1:0]  sum_sat;
    logic signed [DATA_W-1:0]  dif_sat;
    logic [63:0]               biased;
    logic [47:0]               prod_sh;
    logic signed [DATA_W-1:0]  mul_sat;
    logic signed [DATA_W-1:0]  div_q;
    logic                      div_done;

    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);
    assign ra_y     = count_m1[AW-1:0];
    assign ra_x     = count_m2[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
            stk_mem[wa] <= wd;
        rd_x_reg <= stk_mem[ra_x];
        rd_y_reg <= stk_mem[ra_y];
    end

    always_comb
    begin
        we         = 1'b0;
        wa         = count_reg[AW-1:0];
        wd         = opnd_reg;
        count_next = count_reg;
        if (cmd.commit)
        begin
            case (cmd.stk_op)
                SK_PUSH:
                begin
                    we         = 1'b1;
                    wa         = count_reg[AW-1:0];
                    wd         = opnd_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                SK_POP:
                begin
                    we         = 1'b1;
                    wa         = ra_x;
                    wd         = res_reg;
                    count_next = count_m1;
                end
                SK_CLEAR: count_next = '0;
                default:  count_next = count_reg;
            endcase
        end
    end

    assign sum     = {rd_x_reg[DATA_W-1], rd_x_reg} + {rd_y_reg[DATA_W-1], rd_y_reg};
    assign dif     = {rd_x_reg[DATA_W-1], rd_x_reg} - {rd_y_reg[DATA_W-1], rd_y_reg};
    assign sum_sat = (sum[DATA_W] != sum[DATA_W-1]) ? (sum[DATA_W] ? Q_MIN : Q_MAX)
                                                    : sum[DATA_W-1:0];
    assign dif_sat = (dif[DATA_W] != dif[DATA_W-1]) ? (dif[DATA_W] ? Q_MIN : Q_MAX)
                                                    : dif[DATA_W-1:0];

    assign biased  = prod_reg + (prod_reg[63] ? 64'h0000_0000_0000_FFFF : 64'h0);
    assign prod_sh = biased[63:16];
    assign mul_sat = ((&prod_sh[47:31]) || !(|prod_sh[47:31])) ? prod_sh[31:0]
                   : (prod_sh[47] ? Q_MIN : Q_MAX);

    rse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_x_reg),
        .divisor  (rd_y_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        case (cmd.res_sel)
            RS_ZERO:    res_next = '0;
            RS_OPERAND: res_next = opnd_reg;
            RS_TOP:     res_next = rd_y_reg;
            RS_ADD:     res_next = sum_sat;
            RS_SUB:     res_next = dif_sat;
            RS_MUL:     res_next = mul_sat;
            RS_DIV:     res_next = div_q;
            default:    res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= rd_x_reg * rd_y_reg;
        if (cmd.accept)
            opnd_reg <= operand_value;
        if (cmd.res_load)
            res_reg <= res_next;
        if (cmd.commit)
        begin
            status_reg <= cmd.status;
            value_reg  <= res_reg;
            depth_reg  <= count_next;
            fin_reg    <= cmd.finished;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.lt2      = (count_reg < CNT_W'(2));
    assign stat.eq1      = (count_reg == CNT_W'(1));
    assign stat.y_zero   = (rd_y_reg == '0);
    assign stat.div_done = div_done;

    assign status       = status_reg;
    assign result_value = value_reg;
    assign stack_depth  = depth_reg;
    assign finished     = fin_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(STACK_DEPTH))
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.commit && cmd.stk_op == SK_CLEAR, count_reg == '0)
    `ASSERT_IMPL(a_push_room, clk, rst_n, cmd.commit && cmd.stk_op == SK_PUSH, !stat.full)

endmodule

`default_nettype wire

// ===== rtl/rse_ctrl.sv =====
// Controller of the RPN stack evaluator: token decode, sequencing state
// machine and the handshake on both channels. Uses rse_pkg.
`default_nettype none

`include "rpn_stack_evaluator_defines.svh"

module rse_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [rse_pkg::FUNC_W-1:0] func,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output rse_pkg::dp_cmd_t                cmd,
    input  wire rse_pkg::dp_stat_t          stat
);
    import rse_pkg::*;

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                out_busy;
    logic [STAT_W-1:0]   dec_status;
    stk_op_t             dec_stk_op;
    res_sel_t            dec_res_sel;
    logic                dec_fin;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        dec_status  = ST_OK;
        dec_stk_op  = SK_NONE;
        dec_res_sel = RS_ZERO;
        dec_fin     = 1'b0;
        if (func_reg == FN_PUSH)
        begin
            if (stat.full)
            begin
                dec_status  = ST_FULL;
                dec_res_sel = RS_TOP;
            end
            else
            begin
                dec_stk_op  = SK_PUSH;
                dec_res_sel = RS_OPERAND;
            end
        end
        else if (func_reg == FN_END)
        begin
            dec_stk_op = SK_CLEAR;
            dec_fin    = 1'b1;
            if (stat.eq1)
                dec_res_sel = RS_TOP;
            else
                dec_status = ST_BADEND;
        end
        else if (stat.lt2)
        begin
            dec_status = ST_FEW;
            dec_stk_op = SK_CLEAR;
            dec_fin    = 1'b1;
        end
        else
        begin
            case (func_reg)
                FN_ADD:
                begin
                    dec_stk_op  = SK_POP;
                    dec_res_sel = RS_ADD;
                end
                FN_SUB:
                begin
                    dec_stk_op  = SK_POP;
                    dec_res_sel = RS_SUB;
                end
                FN_MUL:
                begin
                    dec_stk_op  = SK_POP;
                    dec_res_sel = RS_MUL;
                end
                FN_DIV:
                begin
                    if (stat.y_zero)
                    begin
                        dec_status = ST_DIV0;
                        dec_stk_op = SK_CLEAR;
                        dec_fin    = 1'b1;
                    end
                    else
                    begin
                        dec_stk_op  = SK_POP;
                        dec_res_sel = RS_DIV;
                    end
                end
                default:
                begin
                    dec_status = ST_BADOP;
                    dec_stk_op = SK_CLEAR;
                    dec_fin    = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (dec_res_sel == RS_MUL)
                    state_next = S_MUL;
                else if (dec_res_sel == RS_DIV)
                    state_next = S_DIV;
                else
                    state_next = S_FIN;
            end
            S_MUL: state_next = S_FIN;
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.res_sel   = dec_res_sel;
        cmd.stk_op    = dec_stk_op;
        cmd.status    = dec_status;
        cmd.finished  = dec_fin;
        case (state_reg)
            S_EXEC:
            begin
                cmd.res_load  = (dec_res_sel != RS_MUL) && (dec_res_sel != RS_DIV);
                cmd.div_start = (dec_res_sel == RS_DIV);
            end
            S_MUL: cmd.res_load = 1'b1;
            S_DIV: cmd.res_load = stat.div_done;
            S_FIN: cmd.commit   = !out_busy;
            default: cmd.res_load = 1'b0;
        endcase
    end

    assign out_valid_next = cmd.commit ? 1'b1 : (out_busy ? 1'b1 : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            func_reg <= func;
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `ASSERT_NEXT(a_div_wait, clk, rst_n, state_reg == S_DIV && !stat.div_done, state_reg == S_DIV)
    `ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, !out_busy && state_reg == S_FIN)

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_evaluator.sv =====
// RPN stack evaluator over signed Q16.16 operands.
// Channels: input word (func, operand_value) on in_valid/in_stall; result word
//   (status, result_value, stack_depth, finished) on out_valid/out_stall.
//   A word moves at a rising edge with valid high and stall low.
// One result word per input word, in order.
// After input acceptance, push, end, add, subtract and every abort go from the
//   execute state to the finish state; multiply passes through a further state
//   (registered 32x32 product, then round and saturate); divide waits in its
//   state for the bit-serial divider that retires one of 48 quotient bits per cycle.
// Throughput: one word at a time; the next input word is taken the cycle
//   after its predecessor's result is loaded into the output register.
// While the receiver stalls, the result word holds; the next input word is
//   accepted and processed, and waits to commit until the output is taken.
// Reset (rst_n low, asynchronous) empties the stack and drops any pending
//   result. Stack contents are not cleared; only entries below the depth are ever
//   used in a result.
// Uses rse_pkg, rse_ctrl, rse_datapath.
`default_nettype none

module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rse_pkg::FUNC_W-1:0]        func,
    input  wire logic signed [rse_pkg::DATA_W-1:0] operand_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [rse_pkg::STAT_W-1:0]             status,
    output logic signed [rse_pkg::DATA_W-1:0]      result_value,
    output logic [CNT_W-1:0]                       stack_depth,
    output logic                                   finished
);
    import rse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    rse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operand_value (operand_value),
        .status        (status),
        .result_value  (result_value),
        .stack_depth   (stack_depth),
        .finished      (finished)
    );

endmodule

`default_nettype wire

// ===== verif/rpn_stack_evaluator_tb.sv =====
// Self-checking testbench for rpn_stack_evaluator: a directed token table, then
// random RPN expressions with noise, checked word by word against a Q16.16 predictor.
// Depends on rse_pkg and the rpn_stack_evaluator RTL only.
module rpn_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rse_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int DEPTH_W      = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 3000;
    localparam longint Q_ONE    = 65536;

    localparam logic [FUNC_W-1:0] FN_BAD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_BAD7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value;
        logic [DEPTH_W-1:0]       depth;
        logic                     fin;
    } rpn_result_t;

    typedef struct {
        logic [FUNC_W-1:0]        fn;
        logic signed [DATA_W-1:0] opv;
        bit                       known;
        rpn_result_t              want;
    } token_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] operand_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] result_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic                     finished;

    token_row_t               token_script[$];
    rpn_result_t              pending_results[$];
    logic signed [DATA_W-1:0] model_stack[DEPTH];
    int                       model_count;
    int                       cur_row;
    int                       directed_count;
    int                       error_count;
    int                       words_in;
    int                       words_out;
    int                       good_ends;
    int                       aborts;
    int                       full_drops;
    int                       idle_cycles;
    bit                       held_off;

    rpn_stack_evaluator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_value  (result_value),
        .stack_depth   (stack_depth),
        .finished      (finished)
    );

    function automatic logic signed [DATA_W-1:0] saturate_q(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    task automatic evaluate_token(input logic [FUNC_W-1:0] fn,
                                  input logic signed [DATA_W-1:0] opv,
                                  output rpn_result_t r);
        longint lhs;
        longint rhs;
        longint exact;
        r = '0;
        r.status = ST_OK;
        exact = 0;
        if (fn == FN_PUSH)
        begin
            if (model_count < DEPTH)
            begin
                model_stack[model_count] = opv;
                model_count++;
            end
            else
                r.status = ST_FULL;
            r.value = model_stack[model_count-1];
        end
        else if (fn == FN_END)
        begin
            r.fin = 1'b1;
            if (model_count == 1)
                r.value = model_stack[0];
            else
                r.status = ST_BADEND;
            model_count = 0;
        end
        else if (model_count < 2)
        begin
            r.status = ST_FEW;
            r.fin = 1'b1;
            model_count = 0;
        end
        else
        begin
            lhs = model_stack[model_count-2];
            rhs = model_stack[model_count-1];
            case (fn)
                FN_ADD: exact = lhs + rhs;
                FN_SUB: exact = lhs - rhs;
                FN_MUL: exact = (lhs * rhs) / Q_ONE;
                FN_DIV:
                begin
                    if (rhs == 0)
                        r.status = ST_DIV0;
                    else
                        exact = (lhs * Q_ONE) / rhs;
                end
                default: r.status = ST_BADOP;
            endcase
            if (r.status != ST_OK)
            begin
                r.fin = 1'b1;
                model_count = 0;
            end
            else
            begin
                model_count--;
                model_stack[model_count-1] = saturate_q(exact);
                r.value = model_stack[model_count-1];
            end
        end
        r.depth = model_count[DEPTH_W-1:0];
    endtask

    task automatic add_token(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] opv);
        token_row_t row;
        row.fn = fn;
        row.opv = opv;
        row.known = 1'b0;
        row.want = '0;
        token_script.push_back(row);
    endtask

    task automatic add_checked(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] opv,
                               input logic [STAT_W-1:0] st, input logic signed [DATA_W-1:0] val,
                               input int dep, input logic fin);
        token_row_t row;
        row.fn = fn;
        row.opv = opv;
        row.known = 1'b1;
        row.want.status = st;
        row.want.value = val;
        row.want.depth = dep[DEPTH_W-1:0];
        row.want.fin = fin;
        token_script.push_back(row);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            return $urandom_range(0, 16 * 65536) - 8 * 65536;
        if (pick < 12)
            return $urandom_range(0, 512 * 65536) - 256 * 65536;
        if (pick < 17)
            return $urandom;
        if (pick == 17)
            return 0;
        case ($urandom_range(0, 3))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return FN_ADD;
            1:       return FN_SUB;
            2:       return FN_MUL;
            default: return FN_DIV;
        endcase
    endfunction

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_expression();
        int depth_now;
        int pushes;
        int target;
        logic [FUNC_W-1:0] noise_fn;
        depth_now = 0;
        pushes = 0;
        target = $urandom_range(1, 6);
        while (pushes < target || depth_now > 1)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                noise_fn = FUNC_W'($urandom_range(0, 7));
                add_token(noise_fn, $urandom);
            end
            if (pushes < target &&
                (depth_now < 2 || (depth_now < DEPTH && $urandom_range(0, 1) == 1)))
            begin
                add_token(FN_PUSH, pick_operand());
                depth_now++;
                pushes++;
            end
            else
            begin
                add_token(pick_operator(), pick_operand());
                depth_now--;
            end
        end
        add_token(FN_END, pick_operand());
    endtask

    task automatic build_script();
        add_checked(FN_END, 0, ST_BADEND, 0, 0, 1'b1);
        add_checked(FN_ADD, 0, ST_FEW, 0, 0, 1'b1);
        add_checked(FN_PUSH, Q_MAX, ST_OK, Q_MAX, 1, 1'b0);
        add_checked(FN_PUSH, Q_MAX, ST_OK, Q_MAX, 2, 1'b0);
        add_checked(FN_ADD, 0, ST_OK, Q_MAX, 1, 1'b0);
        add_checked(FN_PUSH, Q_MIN, ST_OK, Q_MIN, 2, 1'b0);
        add_checked(FN_PUSH, 1, ST_OK, 1, 3, 1'b0);
        add_checked(FN_PUSH, 32'sh0001_0000, ST_OK, 32'sh0001_0000, 4, 1'b0);
        add_checked(FN_PUSH, 5, ST_FULL, 32'sh0001_0000, 4, 1'b0);
        add_token(FN_MUL, 0);
        add_token(FN_SUB, -1);
        add_token(FN_MUL, Q_MAX);
        add_checked(FN_PUSH, 0, ST_OK, 0, 2, 1'b0);
        add_checked(FN_DIV, 0, ST_DIV0, 0, 0, 1'b1);
        add_token(FN_PUSH, 32'shFFFD_0000);
        add_token(FN_PUSH, 32'sh0002_0000);
        add_token(FN_DIV, 0);
        add_token(FN_PUSH, 1);
        add_token(FN_DIV, 0);
        add_token(FN_PUSH, 7);
        add_checked(FN_BAD6, 0, ST_BADOP, 0, 0, 1'b1);
        add_checked(FN_BAD7, 32'sh5555_AAAA, ST_FEW, 0, 0, 1'b1);
        add_token(FN_PUSH, 32'sh0000_8000);
        add_token(FN_PUSH, 0);
        add_checked(FN_END, 0, ST_BADEND, 0, 0, 1'b1);
        add_token(FN_PUSH, -1);
        add_checked(FN_END, 0, ST_OK, -1, 0, 1'b1);
        directed_count = token_script.size();
        while (token_script.size() < directed_count + RANDOM_WORDS)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                repeat (DEPTH + 1) add_token(FN_PUSH, pick_operand());
                add_token(FN_END, pick_operand());
            end
            else
                add_expression();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin : monitor
        rpn_result_t got;
        rpn_result_t want;
        rpn_result_t predicted;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.status = status;
                got.value = result_value;
                got.depth = stack_depth;
                got.fin = finished;
                words_out++;
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending: status %0d value %h",
                           got.status, got.value);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.value !== want.value)
                    begin
                        $error("result_value: expected %h, got %h", want.value, got.value);
                        error_count++;
                    end
                    if (got.depth !== want.depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d", want.depth, got.depth);
                        error_count++;
                    end
                    if (got.fin !== want.fin)
                    begin
                        $error("finished: expected %0d, got %0d", want.fin, got.fin);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                evaluate_token(func, operand_value, predicted);
                if (token_script[cur_row].known)
                    predicted = token_script[cur_row].want;
                pending_results.push_back(predicted);
                words_in++;
                if (predicted.status == ST_FULL)
                    full_drops++;
                else if (predicted.fin && predicted.status == ST_OK)
                    good_ends++;
                else if (predicted.fin)
                    aborts++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin : receiver
        int hold;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held_off && words_in >= 300)
            begin
                held_off = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            hold = (((words_in / 100) % 4) == 1) ? 0 : idle_length();
            if (hold != 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int gap;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_PUSH;
        operand_value = '0;
        cur_row = 0;
        error_count = 0;
        words_in = 0;
        words_out = 0;
        good_ends = 0;
        aborts = 0;
        full_drops = 0;
        idle_cycles = 0;
        held_off = 1'b0;
        model_count = 0;
        foreach (model_stack[i])
            model_stack[i] = '0;
        build_script();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (token_script[i])
        begin
            if (((i / 100) % 4) != 2)
            begin
                gap = idle_length();
                if (gap != 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            cur_row = i;
            func = token_script[i].fn;
            operand_value = token_script[i].opv;
            in_valid = 1'b1;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d words (%0d directed), checked %0d result words.",
                 words_in, directed_count, words_out);
        $display("Saw %0d good ends, %0d aborts and %0d full-stack drops; long output hold %0s.",
                 good_ends, aborts, full_drops, held_off ? "done" : "missed");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== rpn_stack_evaluator.f =====
+incdir+rtl
rtl/rse_pkg.sv
rtl/rse_divider.sv
rtl/rse_datapath.sv
rtl/rse_ctrl.sv
rtl/rpn_stack_evaluator.sv
verif/rpn_stack_evaluator_tb.sv
